### sv/inga_pkg.sv
// Shared types and constants of the in-network gradient aggregator.
package inga_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIR_RD,
        S_DIR_CHK,
        S_COL_RD,
        S_COL_CHK,
        S_NEW,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DIV,
        S_SH_RD,
        S_SH_WR,
        S_PASS,
        S_FIN
    } t_state;

    // Result action codes
    typedef enum logic [1:0] {
        A_HELD = 2'd0,
        A_EMIT = 2'd1,
        A_PASS = 2'd2,
        A_DROP = 2'd3
    } t_action;

    // Configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_LIMIT     = 2'd1;

    // Configuration reset values
    localparam logic [3:0] THRESHOLD_RST = 4'd10;
    localparam logic [6:0] LIMIT_RST     = 7'd50;

endpackage

### sv/in_network_gradient_aggregator_unit.sv
// Top level of the in-network gradient aggregator: sequencer, tables and divider.
//
// Usage: drive i_src_ip, i_src_port and i_payload_word and pulse i_start while
// o_busy is low; the item is taken at that edge. One result follows, shown for
// exactly one cycle with o_valid high: o_action, o_worker_bitmap, o_result_value
// and the leader address/port of worker 0. The receiver cannot stall; results
// are simply presented for one cycle.
// Configuration: i_cfg_valid with i_cfg_index/i_cfg_data, o_cfg_ready is always
// high. Index 0 is the aggregation threshold, index 1 the column limit. Write
// only while idle.
// Sequence: the worker lookup at the taken edge, then a search of the pass-through
// set one entry at a time, a search of the columns for the key (opening a column
// when it is missing), a scan of the columns for one that reached the threshold,
// then on an emit a reciprocal multiply in two halves and a shift of every later
// column down, and last the posting of the result. Each memory gives one read at
// a time, which sets this walk.
// The next item may be taken in the cycle that shows the result.
// Reset: no workers, no columns, pass-through set empty, registers at defaults.
module in_network_gradient_aggregator_unit #(
    parameter int WORKERS      = 4,
    parameter int TABLE_DEPTH  = 64,
    parameter int DIRECT_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_src_ip,
    input  logic [15:0] i_src_port,
    input  logic [31:0] i_payload_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_action,
    output logic [3:0]  o_worker_bitmap,
    output logic [15:0] o_result_value,
    output logic [31:0] o_leader_ip,
    output logic [15:0] o_leader_port
);
    import inga_pkg::*;

    localparam int WW   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int WCW  = $clog2(WORKERS + 1);
    localparam int CAW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNW  = $clog2(TABLE_DEPTH + 1);
    localparam int DAW  = (DIRECT_DEPTH > 1) ? $clog2(DIRECT_DEPTH) : 1;
    localparam int DFW  = $clog2(DIRECT_DEPTH + 1);
    localparam int IW   = (CNW > DFW) ? CNW : DFW;
    localparam int PW   = 36;
    localparam int CMW  = 32 + WORKERS;
    localparam int EMITN = (WORKERS < 4) ? WORKERS : 4;
    localparam logic [3:0] EMIT_MAP = 4'((5'd1 << EMITN) - 5'd1);
    // Reciprocal of the worker count scaled by 2^38, rounded up; exact for sums below 2^35
    localparam logic [39:0] RECIP =
        40'(((64'd1 << 38) + 64'(WORKERS) - 64'd1) / 64'(WORKERS));

    // State and payload registers
    t_state               r_state, n_state;
    logic [31:0]          r_word, n_word;
    logic [WW-1:0]        r_w, n_w;
    logic [47:0]          r_wkeys [WORKERS];
    logic [WCW-1:0]       r_wcnt, n_wcnt;
    logic                 wk_we;
    logic [CNW-1:0]       r_ccnt, n_ccnt;
    logic [DAW-1:0]       r_dptr, n_dptr;
    logic [DFW-1:0]       r_dfill, n_dfill;
    logic [3:0]           r_thr;
    logic [6:0]           r_lim;
    logic [IW-1:0]        r_idx, n_idx;
    logic [PW-1:0]        r_prod, n_prod;
    logic [75:0]          r_acc, n_acc;
    logic                 r_dcnt, n_dcnt;
    logic [1:0]           r_act, n_act;
    logic [3:0]           r_map, n_map;
    logic [15:0]          r_val, n_val;
    logic                 r_ovalid, n_ovalid;

    // Memories and their ports
    logic [CMW-1:0]       col_mem [TABLE_DEPTH];
    logic [CMW-1:0]       r_col_rd;
    logic                 col_re, col_we;
    logic [CAW-1:0]       col_raddr, col_waddr;
    logic [CMW-1:0]       col_wdata;
    logic [31:0]          dir_mem [DIRECT_DEPTH];
    logic [31:0]          r_dir_rd;
    logic                 dir_re, dir_we;

    // Combinational helpers
    logic [CNW-1:0]       lim_eff;
    logic                 w_hit;
    logic [WW-1:0]        w_idx;
    logic [WORKERS-1:0]   w_onehot;
    logic [3:0]           pop;
    logic [19:0]          mul_b;
    logic [55:0]          mul_p;
    logic [WORKERS-1:0]   rd_mask;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign w_onehot    = WORKERS'(1) << r_w;
    assign rd_mask     = r_col_rd[WORKERS-1:0];

    // Shared multiplier: column sum times one half of the reciprocal
    assign mul_b = r_dcnt ? RECIP[39:20] : RECIP[19:0];
    assign mul_p = 56'(r_prod) * 56'(mul_b);

    // Clamp the column limit into 1..TABLE_DEPTH
    always_comb begin
        if (r_lim == 7'd0) begin
            lim_eff = CNW'(1);
        end else if (32'(r_lim) > 32'(TABLE_DEPTH)) begin
            lim_eff = CNW'(TABLE_DEPTH);
        end else begin
            lim_eff = CNW'(r_lim);
        end
    end

    // Look up the arriving source among known workers
    always_comb begin
        w_hit = 1'b0;
        w_idx = '0;
        for (int i = WORKERS - 1; i >= 0; i--) begin
            if ((WCW'(i) < r_wcnt) && (r_wkeys[i] == {i_src_ip, i_src_port})) begin
                w_hit = 1'b1;
                w_idx = WW'(i);
            end
        end
    end

    // Count contributions in the column just read
    always_comb begin
        pop = '0;
        for (int j = 0; j < WORKERS; j++) begin
            pop = pop + 4'(rd_mask[j]);
        end
    end

    // Sequencer: next state, datapath and memory controls
    always_comb begin
        n_state   = r_state;
        n_word    = r_word;
        n_w       = r_w;
        n_wcnt    = r_wcnt;
        n_ccnt    = r_ccnt;
        n_dptr    = r_dptr;
        n_dfill   = r_dfill;
        n_idx     = r_idx;
        n_prod    = r_prod;
        n_acc     = r_acc;
        n_dcnt    = r_dcnt;
        n_act     = r_act;
        n_map     = r_map;
        n_val     = r_val;
        n_ovalid  = 1'b0;
        wk_we     = 1'b0;
        col_re    = 1'b0;
        col_we    = 1'b0;
        col_raddr = r_idx[CAW-1:0];
        col_waddr = r_idx[CAW-1:0];
        col_wdata = {r_word, w_onehot};
        dir_re    = 1'b0;
        dir_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_word = i_payload_word;
                    n_idx  = '0;
                    if (w_hit) begin
                        n_w     = w_idx;
                        n_state = S_DIR_RD;
                    end else if (r_wcnt < WCW'(WORKERS)) begin
                        n_w     = r_wcnt[WW-1:0];
                        wk_we   = 1'b1;
                        n_wcnt  = r_wcnt + WCW'(1);
                        n_state = S_DIR_RD;
                    end else begin
                        n_act   = A_DROP;
                        n_map   = '0;
                        n_val   = '0;
                        n_state = S_FIN;
                    end
                end
            end
            // Search the pass-through set
            S_DIR_RD: begin
                if (r_idx >= IW'(r_dfill)) begin
                    n_idx   = '0;
                    n_state = S_COL_RD;
                end else begin
                    dir_re  = 1'b1;
                    n_state = S_DIR_CHK;
                end
            end
            S_DIR_CHK: begin
                if (r_dir_rd == r_word) begin
                    n_act   = A_PASS;
                    n_map   = (32'(r_w) < 32'(EMITN)) ? 4'(4'd1 << r_w) : 4'd0;
                    n_val   = r_word[15:0];
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_DIR_RD;
                end
            end
            // Search the columns for the key
            S_COL_RD: begin
                if (r_idx >= IW'(r_ccnt)) begin
                    n_state = S_NEW;
                end else begin
                    col_re  = 1'b1;
                    n_state = S_COL_CHK;
                end
            end
            S_COL_CHK: begin
                if (r_col_rd[CMW-1:WORKERS] == r_word) begin
                    if (r_idx >= IW'(lim_eff)) begin
                        n_state = S_PASS;
                    end else begin
                        col_we    = 1'b1;
                        col_wdata = {r_word, rd_mask | w_onehot};
                        n_idx     = '0;
                        n_state   = S_SCAN_RD;
                    end
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_COL_RD;
                end
            end
            // Open a new column
            S_NEW: begin
                if (r_ccnt >= lim_eff) begin
                    n_state = S_PASS;
                end else begin
                    col_we    = 1'b1;
                    col_waddr = r_ccnt[CAW-1:0];
                    n_ccnt    = r_ccnt + CNW'(1);
                    n_idx     = '0;
                    n_state   = S_SCAN_RD;
                end
            end
            // Scan columns for one that reached the threshold
            S_SCAN_RD: begin
                if (r_idx >= IW'(r_ccnt)) begin
                    n_act   = A_HELD;
                    n_map   = '0;
                    n_val   = '0;
                    n_state = S_FIN;
                end else begin
                    col_re  = 1'b1;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (pop >= r_thr) begin
                    n_prod  = PW'(r_col_rd[CMW-1:WORKERS]) * PW'(pop);
                    n_dcnt  = 1'b0;
                    n_state = S_DIV;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            // Divide the column sum by the worker count: low then high reciprocal half
            S_DIV: begin
                if (!r_dcnt) begin
                    n_acc  = 76'(mul_p);
                    n_dcnt = 1'b1;
                end else begin
                    n_acc   = r_acc + {mul_p, 20'd0};
                    n_dcnt  = 1'b0;
                    n_state = S_SH_RD;
                end
            end
            // Remove the emitted column by shifting later ones down
            S_SH_RD: begin
                if ((r_idx + IW'(1)) < IW'(r_ccnt)) begin
                    col_re    = 1'b1;
                    col_raddr = CAW'(r_idx + IW'(1));
                    n_state   = S_SH_WR;
                end else begin
                    n_ccnt  = r_ccnt - CNW'(1);
                    n_act   = A_EMIT;
                    n_map   = EMIT_MAP;
                    n_val   = r_acc[53:38];
                    n_state = S_FIN;
                end
            end
            S_SH_WR: begin
                col_we    = 1'b1;
                col_wdata = r_col_rd;
                n_idx     = r_idx + IW'(1);
                n_state   = S_SH_RD;
            end
            // Record the word as passed through
            S_PASS: begin
                dir_we = 1'b1;
                if (r_dptr == DAW'(DIRECT_DEPTH - 1)) begin
                    n_dptr = '0;
                end else begin
                    n_dptr = r_dptr + DAW'(1);
                end
                if (r_dfill < DFW'(DIRECT_DEPTH)) begin
                    n_dfill = r_dfill + DFW'(1);
                end
                n_act   = A_PASS;
                n_map   = (32'(r_w) < 32'(EMITN)) ? 4'(4'd1 << r_w) : 4'd0;
                n_val   = r_word[15:0];
                n_state = S_FIN;
            end
            S_FIN: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wcnt   <= '0;
            r_ccnt   <= '0;
            r_dptr   <= '0;
            r_dfill  <= '0;
            r_ovalid <= 1'b0;
            r_thr    <= THRESHOLD_RST;
            r_lim    <= LIMIT_RST;
        end else begin
            r_state  <= n_state;
            r_wcnt   <= n_wcnt;
            r_ccnt   <= n_ccnt;
            r_dptr   <= n_dptr;
            r_dfill  <= n_dfill;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && (i_cfg_index == CFG_THRESHOLD)) begin
                r_thr <= i_cfg_data[3:0];
            end
            if (i_cfg_valid && (i_cfg_index == CFG_LIMIT)) begin
                r_lim <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_w    <= n_w;
        r_idx  <= n_idx;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_dcnt <= n_dcnt;
        r_act  <= n_act;
        r_map  <= n_map;
        r_val  <= n_val;
        if (wk_we) begin
            r_wkeys[r_wcnt[WW-1:0]] <= {i_src_ip, i_src_port};
        end
    end

    // Column memory
    always_ff @(posedge i_clk) begin
        if (col_we) begin
            col_mem[col_waddr] <= col_wdata;
        end
        if (col_re) begin
            r_col_rd <= col_mem[col_raddr];
        end
    end

    // Pass-through memory
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[r_dptr] <= r_word;
        end
        if (dir_re) begin
            r_dir_rd <= dir_mem[r_idx[DAW-1:0]];
        end
    end

    // Result ports
    assign o_action        = r_act;
    assign o_worker_bitmap = r_map;
    assign o_result_value  = r_val;
    assign o_leader_ip     = (r_wcnt != '0) ? r_wkeys[0][47:16] : 32'd0;
    assign o_leader_port   = (r_wcnt != '0) ? r_wkeys[0][15:0] : 16'd0;

endmodule

### sim/tb.sv
// Testbench of the in-network gradient aggregator: directed table, then random packets.
`timescale 1ns / 100ps

module tb;
    import inga_pkg::*;

    localparam int NWORK   = 4;
    localparam int NCOL    = 64;
    localparam int NDIRECT = 64;
    localparam int RAND_ITEMS = 1630;
    localparam int PHASE_LEN  = 150;

    typedef struct packed {
        t_action     act;
        logic [3:0]  bitmap;
        logic [15:0] value;
        logic [31:0] lead_ip;
        logic [15:0] lead_port;
    } t_agg_result;

    // One row of the directed table: a register write or a packet
    typedef struct {
        bit          is_cfg;
        logic [1:0]  cfg_idx;
        logic [6:0]  cfg_val;
        int          src;      // worker pool index, -1 for an unknown source
        logic [31:0] word;
        bit          typed;    // expected action/bitmap/value given in the row
        t_action     act;
        logic [3:0]  bitmap;
        logic [15:0] value;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [31:0] i_src_ip = '0;
    logic [15:0] i_src_port = '0;
    logic [31:0] i_payload_word = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        o_valid;
    logic [1:0]  o_action;
    logic [3:0]  o_worker_bitmap;
    logic [15:0] o_result_value;
    logic [31:0] o_leader_ip;
    logic [15:0] o_leader_port;

    in_network_gradient_aggregator_unit dut (.*);

    // Mirror of the aggregator state
    logic [47:0] worker_tab[NWORK];
    int          workers_known = 0;
    logic [31:0] col_key[NCOL];
    logic [32:0] col_slot[NCOL][NWORK];
    int          cols_used = 0;
    logic [32:0] passed_words[NDIRECT];
    int          passed_ptr = 0;
    logic [3:0]  thresh_reg = THRESHOLD_RST;
    logic [6:0]  limit_reg = LIMIT_RST;

    t_agg_result pending_results[$];
    int          fail_count = 0;

    logic [31:0] src_ips[NWORK];
    logic [15:0] src_ports[NWORK];
    logic [31:0] word_pool[12];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("in_network_gradient_aggregator_unit: mismatch");
        $finish;
    end

    function automatic bit was_passed(logic [31:0] word);
        for (int i = 0; i < NDIRECT; i++)
            if (passed_words[i][32] && passed_words[i][31:0] == word) return 1'b1;
        return 1'b0;
    endfunction

    // Store the word in its column; return 0 when the table is full or its column is beyond the limit
    function automatic bit store_contribution(logic [31:0] word, int w);
        int lim;
        lim = (limit_reg == 0) ? 1 : (limit_reg > NCOL ? NCOL : int'(limit_reg));
        for (int c = 0; c < cols_used; c++) begin
            if (col_key[c] == word) begin
                if (c >= lim) return 1'b0;
                col_slot[c][w] = {1'b1, word};
                return 1'b1;
            end
        end
        if (cols_used >= lim) return 1'b0;
        col_key[cols_used] = word;
        for (int j = 0; j < NWORK; j++) col_slot[cols_used][j] = '0;
        col_slot[cols_used][w] = {1'b1, word};
        cols_used++;
        return 1'b1;
    endfunction

    // Work out the result of one packet and advance the mirrored state
    function automatic t_agg_result aggregate_packet(logic [31:0] ip, logic [15:0] port,
                                                     logic [31:0] word);
        t_agg_result r;
        logic [47:0] key;
        logic [35:0] total;
        int          w;
        int          cnt;
        bit          found;
        key = {ip, port};
        r = '{A_HELD, 4'd0, 16'd0, 32'd0, 16'd0};
        w = 0;
        found = 1'b0;
        for (int i = 0; i < workers_known; i++) begin
            if (!found && worker_tab[i] == key) begin
                w = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            if (workers_known < NWORK) begin
                w = workers_known;
                worker_tab[w] = key;
                workers_known++;
            end else begin
                r.act = A_DROP;
            end
        end
        if (r.act != A_DROP) begin
            if (was_passed(word) || !store_contribution(word, w)) begin
                if (!was_passed(word)) begin
                    passed_words[passed_ptr] = {1'b1, word};
                    passed_ptr = (passed_ptr + 1) % NDIRECT;
                end
                r.act = A_PASS;
                r.bitmap = 4'(1 << w);
                r.value = word[15:0];
            end else begin
                for (int c = 0; c < cols_used && r.act == A_HELD; c++) begin
                    total = '0;
                    cnt = 0;
                    for (int j = 0; j < NWORK; j++) begin
                        if (col_slot[c][j][32]) begin
                            total += col_slot[c][j][31:0];
                            cnt++;
                        end
                    end
                    if (cnt >= thresh_reg) begin
                        // drop the column and close the gap
                        for (int k = c; k + 1 < cols_used; k++) begin
                            col_key[k] = col_key[k + 1];
                            col_slot[k] = col_slot[k + 1];
                        end
                        cols_used--;
                        for (int j = 0; j < NWORK; j++) col_slot[cols_used][j] = '0;
                        r.act = A_EMIT;
                        r.bitmap = 4'hF;
                        r.value = 16'(total / NWORK);
                    end
                end
            end
        end
        if (workers_known > 0) begin
            r.lead_ip = worker_tab[0][47:16];
            r.lead_port = worker_tab[0][15:0];
        end
        return r;
    endfunction

    // Present one packet after a random gap; predict it once taken
    task automatic send_packet(logic [31:0] ip, logic [15:0] port, logic [31:0] word,
                               bit typed, t_agg_result typed_res);
        int          gap;
        t_agg_result r;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_src_ip <= ip;
        i_src_port <= port;
        i_payload_word <= word;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        r = aggregate_packet(ip, port, word);
        if (typed) begin
            r.act = typed_res.act;
            r.bitmap = typed_res.bitmap;
            r.value = typed_res.value;
        end
        pending_results = {pending_results, r};
    endtask

    // Write one register once the block has gone idle
    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        @(posedge i_clk);
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_THRESHOLD) thresh_reg = val[3:0];
        else if (idx == CFG_LIMIT) limit_reg = val;
        i_cfg_valid <= 1'b0;
    endtask

    // Compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin
        t_agg_result e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: action %0d", o_action);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_action != e.act) begin
                    $error("action: expected %0d, got %0d", e.act, o_action);
                    fail_count++;
                end
                if (o_worker_bitmap != e.bitmap) begin
                    $error("worker_bitmap: expected %h, got %h", e.bitmap, o_worker_bitmap);
                    fail_count++;
                end
                if (o_result_value != e.value) begin
                    $error("result_value: expected %h, got %h", e.value, o_result_value);
                    fail_count++;
                end
                if (o_leader_ip != e.lead_ip) begin
                    $error("leader_ip: expected %h, got %h", e.lead_ip, o_leader_ip);
                    fail_count++;
                end
                if (o_leader_port != e.lead_port) begin
                    $error("leader_port: expected %h, got %h", e.lead_port, o_leader_port);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_stim_row   rows[$];
        t_agg_result tr;
        logic [6:0]  thr_set[7];
        logic [6:0]  lim_set[7];
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] word;
        int          s;
        for (int i = 0; i < NDIRECT; i++) passed_words[i] = '0;
        for (int c = 0; c < NCOL; c++)
            for (int j = 0; j < NWORK; j++) col_slot[c][j] = '0;
        src_ips[0] = 32'hFFFF_FFFF; src_ports[0] = 16'hFFFF;
        src_ips[1] = 32'h0;         src_ports[1] = 16'h0;
        src_ips[2] = $urandom;      src_ports[2] = 16'($urandom);
        src_ips[3] = $urandom;      src_ports[3] = 16'($urandom);
        for (int i = 0; i < 12; i++) word_pool[i] = $urandom;

        // emits, extremes, drop, limit clamps, repeated pass-through, zero threshold,
        // key column beyond a lowered limit
        rows = '{
            '{1, CFG_THRESHOLD, 7'd2, 0, 0, 0, A_HELD, 0, 0},
            '{0, 0, 0, 0, 32'h0001_2345, 1, A_HELD, 4'h0, 16'h0},
            '{0, 0, 0, 1, 32'h0001_2345, 0, A_HELD, 0, 0},
            '{0, 0, 0, 2, 32'hFFFF_FFFF, 1, A_HELD, 4'h0, 16'h0},
            '{0, 0, 0, 3, 32'hFFFF_FFFF, 1, A_EMIT, 4'hF, 16'hFFFF},
            '{0, 0, 0, -1, 32'h0000_0042, 1, A_DROP, 4'h0, 16'h0},
            '{1, CFG_LIMIT, 7'd0, 0, 0, 0, A_HELD, 0, 0},
            '{0, 0, 0, 0, 32'h0, 1, A_HELD, 4'h0, 16'h0},
            '{0, 0, 0, 1, 32'h5, 1, A_PASS, 4'h2, 16'h5},
            '{0, 0, 0, 2, 32'h5, 1, A_PASS, 4'h4, 16'h5},
            '{0, 0, 0, 1, 32'h0, 1, A_EMIT, 4'hF, 16'h0},
            '{1, CFG_LIMIT, 7'd127, 0, 0, 0, A_HELD, 0, 0},
            '{0, 0, 0, 0, 32'h7, 0, A_HELD, 0, 0},
            '{0, 0, 0, 1, 32'h9, 0, A_HELD, 0, 0},
            '{1, CFG_THRESHOLD, 7'd0, 0, 0, 0, A_HELD, 0, 0},
            '{0, 0, 0, 2, 32'hB, 0, A_HELD, 0, 0},
            '{1, CFG_THRESHOLD, 7'd3, 0, 0, 0, A_HELD, 0, 0},
            '{1, CFG_LIMIT, 7'd1, 0, 0, 0, A_HELD, 0, 0},
            '{0, 0, 0, 3, 32'hB, 1, A_PASS, 4'h8, 16'hB},
            '{0, 0, 0, -1, 32'hFFFF_0000, 1, A_DROP, 4'h0, 16'h0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        foreach (rows[n]) begin
            if (rows[n].is_cfg) begin
                write_reg(rows[n].cfg_idx, rows[n].cfg_val);
            end else begin
                tr = '{rows[n].act, rows[n].bitmap, rows[n].value, 32'd0, 16'd0};
                if (rows[n].src < 0) send_packet(32'h1234_5678, 16'h9ABC, rows[n].word,
                                                 rows[n].typed, tr);
                else send_packet(src_ips[rows[n].src], src_ports[rows[n].src],
                                 rows[n].word, rows[n].typed, tr);
            end
        end

        // random phases, each under its own threshold and column limit
        thr_set = '{7'd1, 7'd2, 7'd3, 7'd4, 7'd0, 7'd15, 7'd0};
        lim_set = '{7'd1, 7'd2, 7'd64, 7'd0, 7'd127, 7'd8, 7'd0};
        tr = '{A_HELD, 4'd0, 16'd0, 32'd0, 16'd0};
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                s = (n / PHASE_LEN) % 7;
                write_reg(CFG_THRESHOLD, (s == 6) ? 7'($urandom) : thr_set[s]);
                write_reg(CFG_LIMIT, (s == 6) ? 7'($urandom) : lim_set[s]);
            end
            if ($urandom_range(0, 15) == 0) word_pool[$urandom_range(0, 11)] = $urandom;
            if ($urandom_range(0, 9) == 0) begin
                ip = $urandom;
                port = 16'($urandom);
            end else begin
                s = $urandom_range(0, NWORK - 1);
                ip = src_ips[s];
                port = src_ports[s];
            end
            word = ($urandom_range(0, 4) == 0) ? $urandom : word_pool[$urandom_range(0, 11)];
            send_packet(ip, port, word, 1'b0, tr);
        end

        @(posedge i_clk);
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("in_network_gradient_aggregator_unit: match");
        end else begin
            $display("in_network_gradient_aggregator_unit: mismatch");
        end
        $finish;
    end
endmodule
